FILE: design/csim_pkg.sv
// Shared types and constants for the streaming cosine similarity core.
`timescale 1ns / 1ps
package csim_pkg;

  localparam int ELEM_W  = 16;
  localparam int DOT_W   = 44;
  localparam int NORM_W  = 43;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;
  localparam int SIM_W   = 16;

  // Accumulated sums of one finished vector pair.
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
  } acc_t;

endpackage

FILE: design/csim_front.sv
// Front end: element products, saturating sums, one pair/cycle unless in_full.
`timescale 1ns / 1ps
module csim_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  logic signed [csim_pkg::ELEM_W-1:0]   in_a_value,
  input  logic signed [csim_pkg::ELEM_W-1:0]   in_b_value,
  input  logic                                 in_is_last,
  output logic                                 in_full,
  input  logic [csim_pkg::QCNT_W-1:0]          q_count,
  output logic                                 q_push,
  output csim_pkg::acc_t                       q_wdata
);
  import csim_pkg::*;

  logic                    s1_vld_r, s1_last_r;
  logic signed [31:0]      pab_r;
  logic [30:0]             paa_r, pbb_r;
  logic signed [DOT_W-1:0] dot_r, dot_nxt;
  logic [NORM_W-1:0]       na_r, na_nxt, nb_r, nb_nxt;
  logic signed [DOT_W:0]   dot_sum;
  logic [NORM_W:0]         na_sum, nb_sum;
  logic signed [31:0]      paa_full, pbb_full;
  logic                    accept;
  logic [QCNT_W:0]         used;

  // A last pair still in the product stage has a queue slot reserved for it.
  assign used    = {1'b0, q_count} + {{QCNT_W{1'b0}}, s1_vld_r & s1_last_r};
  assign in_full = used >= (QCNT_W+1)'(QDEPTH);
  assign accept  = in_push & ~in_full;

  assign paa_full = in_a_value * in_a_value;
  assign pbb_full = in_b_value * in_b_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
    end else begin
      s1_vld_r  <= accept;
      s1_last_r <= in_is_last;
    end
    if (accept) begin
      pab_r <= in_a_value * in_b_value;
      paa_r <= paa_full[30:0];
      pbb_r <= pbb_full[30:0];
    end
  end

  always_comb begin
    dot_sum = {dot_r[DOT_W-1], dot_r} + (DOT_W+1)'(pab_r);
    na_sum  = {1'b0, na_r} + (NORM_W+1)'(paa_r);
    nb_sum  = {1'b0, nb_r} + (NORM_W+1)'(pbb_r);
    if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
      dot_nxt = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      dot_nxt = dot_sum[DOT_W-1:0];
    end
    na_nxt = na_sum[NORM_W] ? {NORM_W{1'b1}} : na_sum[NORM_W-1:0];
    nb_nxt = nb_sum[NORM_W] ? {NORM_W{1'b1}} : nb_sum[NORM_W-1:0];
  end

  assign q_push         = s1_vld_r & s1_last_r;
  assign q_wdata.dot    = dot_nxt;
  assign q_wdata.norm_a = na_nxt;
  assign q_wdata.norm_b = nb_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
    end else if (s1_vld_r) begin
      if (s1_last_r) begin
        dot_r <= '0;
        na_r  <= '0;
        nb_r  <= '0;
      end else begin
        dot_r <= dot_nxt;
        na_r  <= na_nxt;
        nb_r  <= nb_nxt;
      end
    end
  end

endmodule

FILE: design/csim_queue.sv
// Short queue of finished accumulator sets between front and back.
`timescale 1ns / 1ps
module csim_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  csim_pkg::acc_t              wdata,
  input  logic                        pop,
  output csim_pkg::acc_t              rdata,
  output logic                        empty,
  output logic [csim_pkg::QCNT_W-1:0] count
);
  import csim_pkg::*;

  acc_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign empty  = (cnt_r == '0);
  assign count  = cnt_r;
  assign rdata  = mem[rd_r];
  assign do_pop = pop & ~empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

endmodule

FILE: design/csim_back.sv
// Back end: ratio search with one shared 32x32 multiplier, and the result register.
`timescale 1ns / 1ps
module csim_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  csim_pkg::acc_t                      q_rdata,
  output logic                                q_pop,
  input  logic                                out_pop,
  output logic                                out_empty,
  output logic signed [csim_pkg::SIM_W-1:0]   out_similarity,
  output logic                                out_status
);
  import csim_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PROD = 3'd1;
  localparam logic [2:0] ST_TGT  = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_CMP  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]   state_r;
  logic [1:0]   step_r;
  logic [63:0]  na_r, nb_r, mag_r;
  logic         neg_r, stat_r;
  logic [95:0]  prod_r;
  logic [87:0]  mag2_r;
  logic [127:0] acc_r, acc_nxt, addend;
  logic [15:0]  lo_r, hi_r, mid_r, lo_nxt, hi_nxt;
  logic [31:0]  odd2_r;
  logic [31:0]  mul_x, mul_y;
  logic [63:0]  mul_p;
  logic [1:0]   mul_sh;
  logic         oval_r, load_out;
  logic signed [SIM_W-1:0] osim_r, sim_val;
  logic         ostat_r;
  logic [16:0]  mid_sum;
  logic [15:0]  mid_val, odd_val;
  logic [DOT_W-1:0] dot_u;
  logic         le_flag;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + 17'd1;
  assign mid_val = mid_sum[16:1];
  assign odd_val = {mid_val[14:0], 1'b0} - 16'd1;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_x  = '0;
    mul_y  = '0;
    mul_sh = '0;
    case (state_r)
      ST_PROD: begin
        mul_x  = step_r[0] ? na_r[63:32] : na_r[31:0];
        mul_y  = step_r[1] ? nb_r[63:32] : nb_r[31:0];
        mul_sh = {1'b0, step_r[0]} + {1'b0, step_r[1]};
      end
      ST_TGT: begin
        mul_x  = step_r[0] ? mag_r[63:32] : mag_r[31:0];
        mul_y  = step_r[1] ? mag_r[63:32] : mag_r[31:0];
        mul_sh = {1'b0, step_r[0]} + {1'b0, step_r[1]};
      end
      ST_SQ: begin
        mul_x = {16'd0, odd_val};
        mul_y = {16'd0, odd_val};
      end
      ST_MUL: begin
        mul_x  = prod_r[32*step_r +: 32];
        mul_y  = odd2_r;
        mul_sh = step_r;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_x * mul_y;

  always_comb begin
    case (mul_sh)
      2'd0:    addend = {64'd0, mul_p};
      2'd1:    addend = {32'd0, mul_p, 32'd0};
      default: addend = {mul_p, 64'd0};
    endcase
  end

  assign acc_nxt = acc_r + addend;
  // Compare odd^2 * na * nb against mag^2 * 2^32.
  assign le_flag = acc_r <= {8'd0, mag2_r, 32'd0};

  always_comb begin
    if (le_flag) begin
      lo_nxt = mid_r;
      hi_nxt = hi_r;
    end else begin
      lo_nxt = lo_r;
      hi_nxt = mid_r - 16'd1;
    end
  end

  always_comb begin
    if (stat_r) begin
      sim_val = '0;
    end else if (neg_r) begin
      sim_val = 16'd0 - lo_r;
    end else begin
      sim_val = lo_r[15] ? 16'h7FFF : lo_r;
    end
  end

  assign dot_u     = q_rdata.dot[DOT_W-1] ? (DOT_W'(0) - q_rdata.dot) : q_rdata.dot;
  assign q_pop     = (state_r == ST_IDLE) & ~q_empty;
  assign load_out  = (state_r == ST_DONE) & (~oval_r | out_pop);
  assign out_empty = ~oval_r;
  assign out_similarity = osim_r;
  assign out_status     = ostat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      if (load_out) begin
        oval_r <= 1'b1;
      end else if (out_pop) begin
        oval_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            step_r  <= '0;
            state_r <= ((q_rdata.norm_a == '0) || (q_rdata.norm_b == '0)) ? ST_DONE : ST_PROD;
          end
        end
        ST_PROD: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) state_r <= ST_TGT;
        end
        ST_TGT: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) state_r <= ST_SQ;
        end
        ST_SQ: begin
          step_r  <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd2) state_r <= ST_CMP;
        end
        ST_CMP: begin
          state_r <= (lo_nxt < hi_nxt) ? ST_SQ : ST_DONE;
        end
        ST_DONE: begin
          if (load_out) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        na_r   <= 64'(q_rdata.norm_a);
        nb_r   <= 64'(q_rdata.norm_b);
        mag_r  <= 64'(dot_u);
        neg_r  <= q_rdata.dot[DOT_W-1];
        stat_r <= (q_rdata.norm_a == '0) || (q_rdata.norm_b == '0);
        lo_r   <= 16'd0;
        hi_r   <= 16'd32768;
        acc_r  <= '0;
      end
      ST_PROD: begin
        if (step_r == 2'd3) begin
          prod_r <= acc_nxt[95:0];
          acc_r  <= '0;
        end else begin
          acc_r <= acc_nxt;
        end
      end
      ST_TGT: begin
        if (step_r == 2'd3) begin
          mag2_r <= acc_nxt[87:0];
        end
        acc_r <= acc_nxt;
      end
      ST_SQ: begin
        odd2_r <= mul_p[31:0];
        mid_r  <= mid_val;
        acc_r  <= '0;
      end
      ST_MUL: begin
        acc_r <= acc_nxt;
      end
      ST_CMP: begin
        lo_r <= lo_nxt;
        hi_r <= hi_nxt;
      end
      default: ;
    endcase
    if (load_out) begin
      osim_r  <= sim_val;
      ostat_r <= stat_r;
    end
  end

endmodule

FILE: design/cosine_similarity_stream_core.sv
// Top level of the streaming cosine similarity core.
//
//   channel   ports                                 handshake
//   input     in_a_value, in_b_value, in_is_last    in_push / in_full
//   result    out_similarity, out_status            out_pop / out_empty
//
// The front takes one element pair per cycle while in_full is low; a pair goes
// through the product register, then the accumulator. The result comes from a
// bisection search in SQ, MUL and CMP steps on the single shared 32x32 multiplier.
// Up to four finished vectors wait between the front and the ratio search.
// Reset is synchronous; it clears the accumulators, the queue and the result.
// in_full rises only when the queue cannot take another finished vector.
`timescale 1ns / 1ps
module cosine_similarity_stream_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [csim_pkg::ELEM_W-1:0]  in_a_value,
  input  logic signed [csim_pkg::ELEM_W-1:0]  in_b_value,
  input  logic                                in_is_last,
  input  logic                                out_pop,
  output logic                                out_empty,
  output logic signed [csim_pkg::SIM_W-1:0]   out_similarity,
  output logic                                out_status
);
  import csim_pkg::*;

  logic              q_push, q_pop, q_empty;
  acc_t              q_wdata, q_rdata;
  logic [QCNT_W-1:0] q_count;

  csim_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_a_value (in_a_value),
    .in_b_value (in_b_value),
    .in_is_last (in_is_last),
    .in_full    (in_full),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  csim_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  csim_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_similarity (out_similarity),
    .out_status     (out_status)
  );

endmodule

FILE: design/csim_checker.sv
// Port-level checks for the cosine similarity core, bound to the top level.
`timescale 1ns / 1ps
module csim_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_push,
  input logic                                in_full,
  input logic signed [csim_pkg::ELEM_W-1:0]  in_a_value,
  input logic signed [csim_pkg::ELEM_W-1:0]  in_b_value,
  input logic                                in_is_last,
  input logic                                out_pop,
  input logic                                out_empty,
  input logic signed [csim_pkg::SIM_W-1:0]   out_similarity,
  input logic                                out_status
);

  // A waiting item that is not taken stays as it is.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_similarity) && $stable(out_status)))
    else $error("result changed while stalled");

  // A zero-norm item always reports similarity zero.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status) |-> (out_similarity == '0))
    else $error("zero-norm item with nonzero similarity");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

endmodule

bind cosine_similarity_stream_core csim_checker u_csim_checker (.*);

FILE: bench/tb.sv
// Self-checking testbench for the streaming cosine similarity core.
`timescale 1ns / 1ps

class sim_scoreboard;
  logic signed [43:0] dot_sum;
  logic [42:0]        norm_a_sum;
  logic [42:0]        norm_b_sum;
  logic signed [15:0] want_sim[$];
  logic               want_status[$];
  int                 mismatches;
  int                 results_seen;
  int                 zero_norm_seen;

  function new();
    dot_sum = '0;
    norm_a_sum = '0;
    norm_b_sum = '0;
    mismatches = 0;
    results_seen = 0;
    zero_norm_seen = 0;
  endfunction

  // Nearest integer to mag * 2^15 / sqrt(na * nb), clamped to 32767, found by bisection on squares.
  function automatic logic [15:0] ratio_q15(logic [63:0] mag, logic [42:0] na,
                                            logic [42:0] nb);
    logic [255:0] prod;
    logic [255:0] target;
    logic [255:0] odd;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    prod = 256'(na) * 256'(nb);
    target = (256'(mag) * 256'(mag)) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      odd = 256'(2 * mid - 1);
      if (prod * odd * odd <= target) lo = mid;
      else hi = mid - 1;
    end
    if (lo > 32767) lo = 32767;
    return lo[15:0];
  endfunction

  // Unclamped bisection result (can be 32768) for negative similarities.
  function automatic logic [15:0] ratio_raw(logic [63:0] mag, logic [42:0] na,
                                            logic [42:0] nb);
    logic [255:0] prod;
    logic [255:0] target;
    logic [255:0] odd;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    prod = 256'(na) * 256'(nb);
    target = (256'(mag) * 256'(mag)) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      odd = 256'(2 * mid - 1);
      if (prod * odd * odd <= target) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function void note_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    logic signed [47:0] d;
    logic [47:0]        n;
    logic [63:0]        mag;
    logic [15:0]        q;
    d = 48'(dot_sum) + 48'(a * b);
    if (d > 48'sh07FF_FFFF_FFFF) d = 48'sh07FF_FFFF_FFFF;
    if (d < -48'sh0800_0000_0000) d = -48'sh0800_0000_0000;
    dot_sum = d[43:0];
    n = 48'(norm_a_sum) + 48'(unsigned'(32'(a * a)));
    norm_a_sum = (n > 48'h7FF_FFFF_FFFF) ? '1 : n[42:0];
    n = 48'(norm_b_sum) + 48'(unsigned'(32'(b * b)));
    norm_b_sum = (n > 48'h7FF_FFFF_FFFF) ? '1 : n[42:0];
    if (!last) return;
    if (norm_a_sum == 0 || norm_b_sum == 0) begin
      want_sim.push_back('0);
      want_status.push_back(1'b1);
    end else begin
      mag = dot_sum < 0 ? 64'(-64'(dot_sum)) : 64'(dot_sum);
      // A negative result may reach -32768 exactly.
      if (dot_sum < 0) begin
        q = ratio_raw(mag, norm_a_sum, norm_b_sum);
        want_sim.push_back(-$signed({1'b0, q}));
      end else begin
        q = ratio_q15(mag, norm_a_sum, norm_b_sum);
        want_sim.push_back(q);
      end
      want_status.push_back(1'b0);
    end
    dot_sum = '0;
    norm_a_sum = '0;
    norm_b_sum = '0;
  endfunction

  function void check_result(logic signed [15:0] sim, logic status);
    logic signed [15:0] es;
    logic               et;
    results_seen++;
    if (want_sim.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result sim=%0d status=%0d", sim, status);
      return;
    end
    es = want_sim.pop_front();
    et = want_status.pop_front();
    if (et) zero_norm_seen++;
    if (sim !== es || status !== et) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected sim=%0d status=%0d, got sim=%0d status=%0d",
                 results_seen, es, et, sim, status);
    end
  endfunction
endclass

module tb;
  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic signed [15:0] in_a_value;
  logic signed [15:0] in_b_value;
  logic               in_is_last;
  logic               out_pop = 1'b0;
  logic               out_empty;
  logic signed [15:0] out_similarity;
  logic               out_status;

  sim_scoreboard board;
  int  cycle_count = 0;
  int  pairs_sent;
  int  vectors_sent;
  bit  calm;
  int  pop_gap = 0;

  localparam int CYCLE_LIMIT = 900000;

  cosine_similarity_stream_core DUT (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stall bursts, none once the run calms down.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) board.check_result(out_similarity, out_status);
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        out_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        pop_gap <= $urandom_range(1, 18) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    int gap;
    if (!calm && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 18);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_a_value <= a;
    in_b_value <= b;
    in_is_last <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    board.note_pair(a, b, last);
    pairs_sent++;
    if (last) vectors_sent++;
  endtask

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return '0;
      3: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(int len);
    logic signed [15:0] a;
    logic signed [15:0] b;
    int mode;
    mode = $urandom_range(0, 5);
    for (int i = 0; i < len; i++) begin
      a = pick_elem();
      case (mode)
        0: b = a;
        1: b = -a;
        2: b = '0;
        default: b = pick_elem();
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  initial begin
    int len;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_a_value = '0;
    in_b_value = '0;
    in_is_last = 1'b0;
    board = new();
    pairs_sent = 0;
    vectors_sent = 0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single pairs, extremes, zero norms, parallel and opposite vectors.
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_pair(-16'sh8000, -16'sh8000, 1'b1);
    send_pair(-16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh7FFF, -16'sh8000, 1'b1);
    send_pair(16'sh0000, 16'sh0005, 1'b1);
    send_pair(16'sh0003, 16'sh0000, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    send_pair(16'sh0001, 16'sh0001, 1'b0);
    send_pair(16'sh0001, -16'sh0001, 1'b1);
    send_pair(16'sh0003, 16'sh0004, 1'b0);
    send_pair(16'sh0004, 16'sh0003, 1'b1);
    send_pair(16'sh5555, -16'sh2AAB, 1'b0);
    send_pair(-16'sh2AAB, 16'sh5555, 1'b0);
    send_pair(16'sh0001, 16'sh0000, 1'b1);
    send_pair(16'sh0000, 16'sh0001, 1'b0);
    send_pair(16'sh0001, 16'sh0000, 1'b1);

    // Random vectors, mostly short, a few long enough to matter.
    while (pairs_sent < 1750) begin
      if (pairs_sent > 1450) calm = 1'b1;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      send_vector(len);
    end
    in_push <= 1'b0;
    calm = 1'b1;

    while (board.want_sim.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("sent %0d element pairs in %0d vectors; %0d results checked, %0d zero-norm",
             pairs_sent, vectors_sent, board.results_seen, board.zero_norm_seen);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
